FILE: rtl/gbf_pkg.sv
// Package for the graph bridge finder.
// Holds sizes, widths and the sequencer state type; no dependencies.
package gbf_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int EDGE_CW   = EDGE_AW + 1;
  localparam int KEY_W     = 2 * NODE_W;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EDGE,
    S_BACK,
    S_POP_RD,
    S_POP,
    S_SEL_RD,
    S_SEL_CMP,
    S_SEL_EMIT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/graph_bridge_finder.sv
// Graph bridge finder top level: edge store, depth-first search sequencer
// and sorted result emission. Depends on gbf_pkg.
// Edge items are stored while idle. The last item starts a depth-first search over the
// stored edges from vertex 0, followed by a selection scan for each bridge. Throughput:
// one graph at a time; the input stalls until the last result item is accepted.
// Reset: synchronous, active low.
module graph_bridge_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gbf_pkg::NODE_W-1:0]    in_node_a,
  input  logic [gbf_pkg::NODE_W-1:0]    in_node_b,
  input  logic                          in_edge_valid,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gbf_pkg::NODE_W-1:0]    out_bridge_count,
  output logic [gbf_pkg::NODE_W-1:0]    out_low_end,
  output logic [gbf_pkg::NODE_W-1:0]    out_high_end,
  output logic                          out_bridge_valid,
  output logic                          out_last_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbf_pkg::ADDR_W-1:0]    paddr,
  input  logic [gbf_pkg::DATA_W-1:0]    pwdata,
  output logic [gbf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int NW = gbf_pkg::NODE_W;
  localparam int CW = gbf_pkg::CNT_W;
  localparam int EA = gbf_pkg::EDGE_AW;
  localparam int EC = gbf_pkg::EDGE_CW;
  localparam int KW = gbf_pkg::KEY_W;

  gbf_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  ncnt_r;
  logic [CW-1:0]  lim;
  logic [EC-1:0]  etot_r;

  logic [KW-1:0]  edge_mem [gbf_pkg::MAX_EDGES];
  logic [NW-1:0]  disc_mem [gbf_pkg::MAX_NODES];
  logic [NW-1:0]  low_mem  [gbf_pkg::MAX_NODES];
  logic [NW-1:0]  par_mem  [gbf_pkg::MAX_NODES];
  logic [NW-1:0]  stk_mem  [gbf_pkg::MAX_NODES];
  logic [EC-1:0]  cur_mem  [gbf_pkg::MAX_NODES];
  logic [KW-1:0]  key_mem  [gbf_pkg::MAX_NODES];

  logic [KW-1:0]  edge_rd_r;
  logic [NW-1:0]  disc_rd_r, low_rd_r, par_rd_r, stk_rd_r;
  logic [EC-1:0]  cur_rd_r;
  logic [KW-1:0]  key_rd_r;

  logic [gbf_pkg::MAX_NODES-1:0] visited_r;
  logic [gbf_pkg::MAX_NODES-1:0] bflag_r;

  logic [NW-1:0]  v_r, low_r, par_r, cv_r, cl_r;
  logic [EC-1:0]  cur_r;
  logic [CW-1:0]  depth_r, vc_r, bcnt_r, ecnt_r;
  logic [NW-1:0]  s_r, bestv_r;
  logic [KW-1:0]  best_r;
  logic           have_r;

  logic           in_acc, cfg_wr, start, empty_go;
  logic [NW-1:0]  ea, eb, nb, disc_ra, bu;
  logic           e_ok, e_desc, e_back, bridge_hit;
  logic [NW-1:0]  new_low;

  assign in_stall = (state_r != gbf_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? {{(gbf_pkg::DATA_W-CW){1'b0}}, ncnt_r} : '0;

  assign lim = (ncnt_r > CW'(gbf_pkg::MAX_NODES)) ? CW'(gbf_pkg::MAX_NODES) : ncnt_r;

  assign ea     = edge_rd_r[NW-1:0];
  assign eb     = edge_rd_r[KW-1:NW];
  assign nb     = (ea == v_r) ? eb : ea;
  assign e_ok   = ({1'b0, ea} < lim) && ({1'b0, eb} < lim) && ((ea == v_r) || (eb == v_r));
  assign e_desc = e_ok && !visited_r[nb];
  assign e_back = e_ok && visited_r[nb] && (par_r != nb);
  assign disc_ra = (state_r == gbf_pkg::S_EDGE) ? nb : stk_rd_r;

  assign start    = in_acc && in_last_edge && (lim != '0);
  assign empty_go = in_acc && in_last_edge && (lim == '0);
  assign new_low    = (cl_r < low_rd_r) ? cl_r : low_rd_r;
  assign bridge_hit = (cl_r > disc_rd_r);
  assign bu         = stk_rd_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbf_pkg::S_IDLE: begin
        if (start) state_nxt = gbf_pkg::S_SCAN;
        else if (empty_go) state_nxt = gbf_pkg::S_OUT;
      end
      gbf_pkg::S_SCAN: begin
        if (cur_r < etot_r) state_nxt = gbf_pkg::S_EDGE;
        else if (depth_r > CW'(1)) state_nxt = gbf_pkg::S_POP_RD;
        else if (bcnt_r == '0) state_nxt = gbf_pkg::S_OUT;
        else state_nxt = gbf_pkg::S_SEL_RD;
      end
      gbf_pkg::S_EDGE: begin
        if (e_back) state_nxt = gbf_pkg::S_BACK;
        else state_nxt = gbf_pkg::S_SCAN;
      end
      gbf_pkg::S_BACK:     state_nxt = gbf_pkg::S_SCAN;
      gbf_pkg::S_POP_RD:   state_nxt = gbf_pkg::S_POP;
      gbf_pkg::S_POP:      state_nxt = gbf_pkg::S_SCAN;
      gbf_pkg::S_SEL_RD:   state_nxt = gbf_pkg::S_SEL_CMP;
      gbf_pkg::S_SEL_CMP: begin
        if (s_r == '1) state_nxt = gbf_pkg::S_SEL_EMIT;
        else state_nxt = gbf_pkg::S_SEL_RD;
      end
      gbf_pkg::S_SEL_EMIT: state_nxt = gbf_pkg::S_OUT;
      gbf_pkg::S_OUT: begin
        if (!out_stall) begin
          if (out_last_result) state_nxt = gbf_pkg::S_IDLE;
          else state_nxt = gbf_pkg::S_SEL_RD;
        end
      end
      default: state_nxt = gbf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_edge_valid && (etot_r < EC'(gbf_pkg::MAX_EDGES))) begin
      edge_mem[etot_r[EA-1:0]] <= {in_node_b, in_node_a};
    end
    if (state_r == gbf_pkg::S_SCAN) begin
      edge_rd_r <= edge_mem[cur_r[EA-1:0]];
      stk_rd_r  <= stk_mem[NW'(depth_r - CW'(2))];
    end
    disc_rd_r <= disc_mem[disc_ra];
    low_rd_r  <= low_mem[bu];
    par_rd_r  <= par_mem[bu];
    cur_rd_r  <= cur_mem[bu];
    key_rd_r  <= key_mem[s_r];
    if (start) begin
      disc_mem[0] <= '0;
      par_mem[0]  <= '0;
      stk_mem[0]  <= '0;
    end
    if (state_r == gbf_pkg::S_EDGE && e_desc) begin
      cur_mem[v_r] <= cur_r + EC'(1);
      low_mem[v_r] <= low_r;
      disc_mem[nb] <= vc_r[NW-1:0];
      par_mem[nb]  <= v_r;
      stk_mem[depth_r[NW-1:0]] <= nb;
    end
    if (state_r == gbf_pkg::S_POP && bridge_hit) begin
      key_mem[cv_r] <= (bu < cv_r) ? {bu, cv_r} : {cv_r, bu};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r    <= CW'(gbf_pkg::MAX_NODES);
      etot_r    <= '0;
      out_valid <= 1'b0;
      visited_r <= '0;
      bflag_r   <= '0;
      depth_r   <= '0;
      vc_r      <= '0;
      bcnt_r    <= '0;
      ecnt_r    <= '0;
      s_r       <= '0;
      have_r    <= 1'b0;
    end else begin
      if (cfg_wr) ncnt_r <= pwdata[CW-1:0];
      if (in_acc && in_edge_valid && (etot_r < EC'(gbf_pkg::MAX_EDGES))) begin
        etot_r <= etot_r + EC'(1);
      end
      if (start) begin
        visited_r    <= {{(gbf_pkg::MAX_NODES-1){1'b0}}, 1'b1};
        bflag_r      <= '0;
        depth_r      <= CW'(1);
        vc_r         <= CW'(1);
        bcnt_r       <= '0;
        ecnt_r       <= '0;
        s_r          <= '0;
        have_r       <= 1'b0;
        v_r          <= '0;
        par_r        <= '0;
        low_r        <= '0;
        cur_r        <= '0;
      end
      if (empty_go) begin
        bcnt_r <= '0;
        ecnt_r <= '0;
      end
      case (state_r)
        gbf_pkg::S_SCAN: begin
          if (!(cur_r < etot_r) && depth_r > CW'(1)) begin
            depth_r <= depth_r - CW'(1);
            cv_r    <= v_r;
            cl_r    <= low_r;
          end
        end
        gbf_pkg::S_EDGE: begin
          if (e_desc) begin
            visited_r[nb] <= 1'b1;
            depth_r <= depth_r + CW'(1);
            vc_r    <= vc_r + CW'(1);
            v_r     <= nb;
            par_r   <= v_r;
            low_r   <= vc_r[NW-1:0];
            cur_r   <= '0;
          end else begin
            cur_r <= cur_r + EC'(1);
          end
        end
        gbf_pkg::S_BACK: begin
          if (disc_rd_r < low_r) low_r <= disc_rd_r;
        end
        gbf_pkg::S_POP: begin
          v_r   <= bu;
          cur_r <= cur_rd_r;
          par_r <= par_rd_r;
          low_r <= new_low;
          if (bridge_hit) begin
            bflag_r[cv_r] <= 1'b1;
            bcnt_r <= bcnt_r + CW'(1);
          end
        end
        gbf_pkg::S_SEL_CMP: begin
          if (bflag_r[s_r] && (!have_r || key_rd_r < best_r)) begin
            have_r  <= 1'b1;
            best_r  <= key_rd_r;
            bestv_r <= s_r;
          end
          s_r <= s_r + NW'(1);
        end
        gbf_pkg::S_SEL_EMIT: begin
          bflag_r[bestv_r] <= 1'b0;
          ecnt_r <= ecnt_r + CW'(1);
        end
        gbf_pkg::S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            s_r       <= '0;
            have_r    <= 1'b0;
            if (out_last_result) etot_r <= '0;
          end
        end
        default: begin
        end
      endcase
      if ((state_r == gbf_pkg::S_SCAN && state_nxt == gbf_pkg::S_OUT) || empty_go) begin
        out_valid        <= 1'b1;
        out_bridge_count <= '0;
        out_low_end      <= '0;
        out_high_end     <= '0;
        out_bridge_valid <= 1'b0;
        out_last_result  <= 1'b1;
      end
      if (state_r == gbf_pkg::S_SEL_EMIT) begin
        out_valid        <= 1'b1;
        out_bridge_count <= bcnt_r[NW-1:0];
        out_low_end      <= best_r[KW-1:NW];
        out_high_end     <= best_r[NW-1:0];
        out_bridge_valid <= 1'b1;
        out_last_result  <= (ecnt_r + CW'(1)) == bcnt_r;
      end
    end
  end

endmodule
